/* rtl/mrf_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request framer.
// Depends on nothing; every other file of the framer refers to it by scoped names.

package mrf_pkg;

  localparam int MAX_DATA_BYTES = 252;

  localparam logic [7:0] HEAD_SINGLE = 8'd4;
  localparam logic [7:0] HEAD_MULTI = 8'd5;
  localparam logic [7:0] COUNT_LIMIT = 8'(MAX_DATA_BYTES - 5);

  localparam logic [7:0] FC_READ_COILS = 8'd1;
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL = 8'd5;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS = 8'd16;

  localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CRC_ERROR = 3'd1;
  localparam logic [2:0] ST_ILLEGAL_FUNC = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_CODE = 3'd3;
  localparam logic [2:0] ST_COUNT_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [1:0] {
    FC_SINGLE,
    FC_MULTI,
    FC_OTHER
  } fc_class_t;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_FUNC,
    PH_HEAD,
    PH_DATA,
    PH_CRCL,
    PH_CRCH,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic       is_timeout;
    logic [7:0] rx_byte;
    fc_class_t  fc_class;
    logic       count_too_big;
  } cmd_t;

  typedef struct packed {
    logic       is_frame_end;
    logic [7:0] frame_byte;
    logic [8:0] byte_position;
    logic [2:0] frame_status;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/modbus_rtu_request_framer_unit.sv */
// Top level of the Modbus RTU slave request framer.
// Depends on mrf_pkg, mrf_front, mrf_cmdq and mrf_back.
//
// The input channel is a queue write port: a beat is taken when in_push is high and in_full
// is low. Each beat is either a received byte (in_action low) or a t3.5 silence event
// (in_action high). The result channel is a queue read port: while out_empty is low the
// oldest result is on the out_ ports, and it is taken when out_pop is high.
// Each input beat gives at most one result: a frame byte with its position, or a frame end
// with its status. One input beat is taken every cycle while in_full is low; the back end
// handles one command per cycle while the result queue is not full, the CRC-16 byte update
// being an unrolled combinational step.
// The slave address is written on the cfg_ channel, which is always ready; it should only
// be written while no frame bytes are in flight.
// Reset empties both queues, sets the slave address to 1 and makes the framer await an
// address byte with a fresh CRC.
// When the receiver stalls, the two-entry result queue fills, the back end stops taking
// commands, the four-entry command queue fills and in_full rises; nothing is lost.

module modbus_rtu_request_framer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_action,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_is_frame_end,
  output logic [7:0] out_frame_byte,
  output logic [8:0] out_byte_position,
  output logic [2:0] out_frame_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_slave_address
);

  logic             cfg_we;
  logic [7:0]       slave_addr_r;
  logic             q_push, q_full, q_valid, q_pop;
  mrf_pkg::cmd_t    q_cmd, head_cmd;
  mrf_pkg::result_t res_head;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mrf_pkg::SLAVE_ADDR_RESET;
    end else if (cfg_we) begin
      slave_addr_r <= cfg_slave_address;
    end
  end

  mrf_front u_front (
    .in_push    (in_push),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  mrf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  mrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .slave_address (slave_addr_r),
    .cmd_valid     (q_valid),
    .cmd           (head_cmd),
    .cmd_pop       (q_pop),
    .res_empty     (out_empty),
    .res_pop       (out_pop),
    .res_head      (res_head)
  );

  assign out_is_frame_end = res_head.is_frame_end;
  assign out_frame_byte = res_head.frame_byte;
  assign out_byte_position = res_head.byte_position;
  assign out_frame_status = res_head.frame_status;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end took a command from an empty queue");

  a_frame_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_frame_end) |-> (out_frame_byte == 8'd0))
    else $error("frame end result carries a byte");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_frame_end) |-> (out_frame_status == mrf_pkg::ST_OK))
    else $error("payload result carries a status");

  a_empty_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

/* rtl/mrf_front.sv */
// Front end of the framer: takes input beats and classifies each byte for the back end.
// Depends on mrf_pkg for the command type and the function code constants.

module mrf_front (
  input  logic          in_push,
  input  logic          in_action,
  input  logic [7:0]    in_rx_byte,
  output logic          in_full,
  input  logic          q_full,
  output logic          q_push,
  output mrf_pkg::cmd_t q_cmd
);

  mrf_pkg::fc_class_t fc_class;

  always_comb begin
    if (in_rx_byte == mrf_pkg::FC_READ_COILS || in_rx_byte == mrf_pkg::FC_READ_HOLDING ||
        in_rx_byte == mrf_pkg::FC_WRITE_COIL) begin
      fc_class = mrf_pkg::FC_SINGLE;
    end else if (in_rx_byte == mrf_pkg::FC_WRITE_COILS ||
                 in_rx_byte == mrf_pkg::FC_WRITE_REGS) begin
      fc_class = mrf_pkg::FC_MULTI;
    end else begin
      fc_class = mrf_pkg::FC_OTHER;
    end
  end

  assign in_full = q_full;
  assign q_push = in_push && !q_full;

  always_comb begin
    q_cmd.is_timeout = in_action;
    q_cmd.rx_byte = in_rx_byte;
    q_cmd.fc_class = fc_class;
    q_cmd.count_too_big = in_rx_byte > mrf_pkg::COUNT_LIMIT;
  end

endmodule

/* rtl/mrf_cmdq.sv */
// Short command queue between the front end and the back end of the framer.
// Depends on mrf_pkg for the command type and the queue depth.

module mrf_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output mrf_pkg::cmd_t head_cmd
);

  mrf_pkg::cmd_t mem [mrf_pkg::CMDQ_DEPTH];

  logic [mrf_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mrf_pkg::CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mrf_pkg::CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full = count_r == mrf_pkg::CMDQ_CNT_W'(mrf_pkg::CMDQ_DEPTH);
  assign valid = count_r != '0;
  assign head_cmd = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + mrf_pkg::CMDQ_CNT_W'(do_push) - mrf_pkg::CMDQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/mrf_back.sv */
// Back end of the framer: runs the frame state machine and the CRC-16 check on each command
// and holds finished result beats in a two-entry queue. Depends on mrf_pkg.

module mrf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       slave_address,
  input  logic             cmd_valid,
  input  mrf_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_empty,
  input  logic             res_pop,
  output mrf_pkg::result_t res_head
);

  mrf_pkg::phase_t phase_r, phase_nxt;
  logic            multi_r, multi_nxt;
  logic [7:0]      bytes_left_r, bytes_left_nxt;
  logic [8:0]      pos_r, pos_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_low_r, crc_low_nxt;

  mrf_pkg::result_t resq [mrf_pkg::RESQ_DEPTH];

  logic [mrf_pkg::RESQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mrf_pkg::RESQ_CNT_W-1:0] count_r;
  logic                           resq_full, res_do_pop;

  logic             emit_byte, emit_end, res_we;
  logic [2:0]       end_status;
  mrf_pkg::result_t res;
  logic [7:0]       b;

  assign resq_full = count_r == mrf_pkg::RESQ_CNT_W'(mrf_pkg::RESQ_DEPTH);
  assign res_empty = count_r == '0;
  assign res_head = resq[rd_ptr_r];
  assign res_do_pop = res_pop && !res_empty;
  assign cmd_pop = cmd_valid && !resq_full;
  assign b = cmd.rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    multi_nxt = multi_r;
    bytes_left_nxt = bytes_left_r;
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    crc_low_nxt = crc_low_r;
    emit_byte = 1'b0;
    emit_end = 1'b0;
    end_status = mrf_pkg::ST_OK;
    res = '0;
    res_we = 1'b0;
    if (cmd_pop) begin
      if (cmd.is_timeout) begin
        if (phase_r != mrf_pkg::PH_ADDR && phase_r != mrf_pkg::PH_SKIP) begin
          emit_end = 1'b1;
          end_status = mrf_pkg::ST_TIMEOUT;
        end
      end else begin
        unique case (phase_r)
          mrf_pkg::PH_ADDR: begin
            if (b == slave_address) begin
              emit_byte = 1'b1;
              phase_nxt = mrf_pkg::PH_FUNC;
            end else begin
              phase_nxt = mrf_pkg::PH_SKIP;
            end
          end
          mrf_pkg::PH_FUNC: begin
            unique case (cmd.fc_class)
              mrf_pkg::FC_SINGLE: begin
                emit_byte = 1'b1;
                multi_nxt = 1'b0;
                bytes_left_nxt = mrf_pkg::HEAD_SINGLE;
                phase_nxt = mrf_pkg::PH_HEAD;
              end
              mrf_pkg::FC_MULTI: begin
                emit_byte = 1'b1;
                multi_nxt = 1'b1;
                bytes_left_nxt = mrf_pkg::HEAD_MULTI;
                phase_nxt = mrf_pkg::PH_HEAD;
              end
              default: begin
                emit_end = 1'b1;
                end_status = mrf_pkg::ST_UNKNOWN_CODE;
              end
            endcase
          end
          mrf_pkg::PH_HEAD: begin
            emit_byte = 1'b1;
            if (bytes_left_r <= 8'd1) begin
              bytes_left_nxt = '0;
              if (multi_r) begin
                if (cmd.count_too_big) begin
                  emit_byte = 1'b0;
                  emit_end = 1'b1;
                  end_status = mrf_pkg::ST_COUNT_TOO_LARGE;
                end else begin
                  bytes_left_nxt = b;
                  phase_nxt = (b != 8'd0) ? mrf_pkg::PH_DATA : mrf_pkg::PH_CRCL;
                end
              end else begin
                phase_nxt = mrf_pkg::PH_CRCL;
              end
            end else begin
              bytes_left_nxt = bytes_left_r - 8'd1;
            end
          end
          mrf_pkg::PH_DATA: begin
            emit_byte = 1'b1;
            if (bytes_left_r <= 8'd1) begin
              bytes_left_nxt = '0;
              phase_nxt = mrf_pkg::PH_CRCL;
            end else begin
              bytes_left_nxt = bytes_left_r - 8'd1;
            end
          end
          mrf_pkg::PH_CRCL: begin
            crc_low_nxt = b;
            phase_nxt = mrf_pkg::PH_CRCH;
          end
          mrf_pkg::PH_CRCH: begin
            emit_end = 1'b1;
            if ({b, crc_low_r} != crc_r) begin
              end_status = mrf_pkg::ST_CRC_ERROR;
            end else if (multi_r) begin
              end_status = mrf_pkg::ST_ILLEGAL_FUNC;
            end else begin
              end_status = mrf_pkg::ST_OK;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (emit_byte) begin
      res_we = 1'b1;
      res.is_frame_end = 1'b0;
      res.frame_byte = b;
      res.byte_position = pos_r;
      res.frame_status = mrf_pkg::ST_OK;
      crc_nxt = mrf_pkg::crc_feed(crc_r, b);
      pos_nxt = pos_r + 9'd1;
    end
    if (emit_end) begin
      res_we = 1'b1;
      res.is_frame_end = 1'b1;
      res.frame_byte = '0;
      res.byte_position = pos_r;
      res.frame_status = end_status;
      phase_nxt = mrf_pkg::PH_SKIP;
    end

    if (cmd_pop && cmd.is_timeout) begin
      phase_nxt = mrf_pkg::PH_ADDR;
      multi_nxt = 1'b0;
      bytes_left_nxt = '0;
      pos_nxt = '0;
      crc_nxt = mrf_pkg::CRC_INIT;
      crc_low_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mrf_pkg::PH_ADDR;
      multi_r <= 1'b0;
      bytes_left_r <= '0;
      pos_r <= '0;
      crc_r <= mrf_pkg::CRC_INIT;
      crc_low_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      multi_r <= multi_nxt;
      bytes_left_r <= bytes_left_nxt;
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      crc_low_r <= crc_low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (res_we) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (res_do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + mrf_pkg::RESQ_CNT_W'(res_we) - mrf_pkg::RESQ_CNT_W'(res_do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      resq[wr_ptr_r] <= res;
    end
  end

endmodule
